/* hdl/afs_pkg.sv */
package afs_pkg;

  localparam int RawW   = 12;
  localparam int SpeedW = 14;
  localparam int SegW   = 4;
  localparam int WinW   = 10;
  localparam int DvW    = 11;
  localparam int QuoW   = 11;
  localparam int NumW   = DvW + WinW;

  localparam logic [RawW-1:0]   RawFloor   = 12'd409;
  localparam logic [RawW-1:0]   RawCeil    = 12'd3686;
  localparam logic [SpeedW-1:0] MaxSpeed7  = 14'd7230;
  localparam logic [SpeedW-1:0] MaxSpeed15 = 14'd15000;
  localparam int Points7  = 9;
  localparam int Points15 = 13;
  localparam int MaxPoints = Points15;

  // pipeline depth: front, lookup, multiply, one stage per quotient bit, output
  localparam int NumStages = 3 + QuoW + 1;

  typedef struct packed {
    logic [RawW-1:0] raw;
    logic            ok;
    logic            lo;
    logic            hi;
    logic            rsel;
    logic [SegW-1:0] seg;
  } front_t;

  typedef struct packed {
    logic [RawW-1:0]   raw;
    logic              ok;
    logic              lo;
    logic              hi;
    logic              rsel;
    logic [SpeedW-1:0] v0;
    logic [WinW-1:0]   win;
    logic [DvW-1:0]    dv;
    logic [WinW-1:0]   offs;
  } lookup_t;

  typedef struct packed {
    logic [RawW-1:0]   raw;
    logic              ok;
    logic              lo;
    logic              hi;
    logic              rsel;
    logic [SpeedW-1:0] v0;
    logic [WinW-1:0]   win;
    logic [NumW-1:0]   rem;
    logic [QuoW-1:0]   quo;
  } div_t;

  typedef struct packed {
    logic [RawW-1:0]   raw;
    logic [SpeedW-1:0] speed;
    logic              ok;
  } result_t;

  function automatic logic [RawW-1:0] bp_raw(input logic rsel, input logic [SegW-1:0] idx);
    logic [RawW-1:0] r;
    r = '0;
    if (rsel) begin
      case (idx)
        4'd0:    r = 12'd409;
        4'd1:    r = 12'd1203;
        4'd2:    r = 12'd1597;
        4'd3:    r = 12'd1908;
        4'd4:    r = 12'd2187;
        4'd5:    r = 12'd2400;
        4'd6:    r = 12'd2629;
        4'd7:    r = 12'd2801;
        4'd8:    r = 12'd3006;
        4'd9:    r = 12'd3178;
        4'd10:   r = 12'd3309;
        4'd11:   r = 12'd3563;
        4'd12:   r = 12'd3686;
        default: r = 12'd3686;
      endcase
    end else begin
      case (idx)
        4'd0:    r = 12'd409;
        4'd1:    r = 12'd915;
        4'd2:    r = 12'd1522;
        4'd3:    r = 12'd2066;
        4'd4:    r = 12'd2523;
        4'd5:    r = 12'd2908;
        4'd6:    r = 12'd3256;
        4'd7:    r = 12'd3572;
        4'd8:    r = 12'd3686;
        default: r = 12'd3686;
      endcase
    end
    return r;
  endfunction

  function automatic logic [SpeedW-1:0] bp_speed(input logic rsel,
                                                 input logic [SegW-1:0] idx);
    logic [SpeedW-1:0] v;
    v = '0;
    if (rsel) begin
      case (idx)
        4'd0:    v = 14'd0;
        4'd1:    v = 14'd2000;
        4'd2:    v = 14'd3000;
        4'd3:    v = 14'd4000;
        4'd4:    v = 14'd5000;
        4'd5:    v = 14'd6000;
        4'd6:    v = 14'd7000;
        4'd7:    v = 14'd8000;
        4'd8:    v = 14'd9000;
        4'd9:    v = 14'd10000;
        4'd10:   v = 14'd11000;
        4'd11:   v = 14'd13000;
        4'd12:   v = 14'd15000;
        default: v = 14'd15000;
      endcase
    end else begin
      case (idx)
        4'd0:    v = 14'd0;
        4'd1:    v = 14'd1070;
        4'd2:    v = 14'd2010;
        4'd3:    v = 14'd3000;
        4'd4:    v = 14'd3970;
        4'd5:    v = 14'd4960;
        4'd6:    v = 14'd5980;
        4'd7:    v = 14'd6990;
        4'd8:    v = 14'd7230;
        default: v = 14'd7230;
      endcase
    end
    return v;
  endfunction

endpackage

/* hdl/afs_if.sv */
interface afs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] checksum_byte;
  logic [7:0] flow_high;
  logic [7:0] flow_low;
  logic [7:0] extra_a;
  logic [7:0] extra_b;

  modport source (output valid, output checksum_byte, output flow_high, output flow_low,
                  output extra_a, output extra_b, input ready);
  modport sink (input valid, input checksum_byte, input flow_high, input flow_low,
                input extra_a, input extra_b, output ready);
endinterface

interface afs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] raw_flow;
  logic [13:0] speed_mm_per_s;
  logic        checksum_ok;

  modport source (output valid, output raw_flow, output speed_mm_per_s, output checksum_ok,
                  input ready);
  modport sink (input valid, input raw_flow, input speed_mm_per_s, input checksum_ok,
                output ready);
endinterface

/* hdl/airflow_frame_to_speed_core.sv */
// Converts one five-byte airflow sensor frame per item into the 12-bit raw flow value, a
// checksum flag and the air speed in mm/s, interpolated on the breakpoint table chosen by
// range_select and truncated. Throughput is one item per clock while the output is not
// stalled. An item passes through 15 register stages: one stage for nibble assembly,
// checksum and segment search, one for the table lookup, one for the multiply, eleven
// for the divider that resolves one quotient bit per stage, and the output register.
// Every stage has its own valid bit and stalls only when the stage after it is full and
// stalled, so bubbles are squeezed out under backpressure. The user writes range_select
// through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce this.
module airflow_frame_to_speed_core
  import afs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  afs_in_if.sink   in_if,
  afs_out_if.source out_if
);

  logic range_select_q;

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   adv;

  front_t  front_d, front_q;
  lookup_t look_d, look_q;
  div_t    mul_d, mul_q;
  div_t    div_in [QuoW];
  div_t    div_d  [QuoW];
  div_t    div_q  [QuoW];
  result_t res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_select_q <= 1'b0;
    end else if (cfg_we_i) begin
      range_select_q <= cfg_wdata_i;
    end
  end

  // stage advance, from the output back
  always_comb begin
    adv[NumStages] = out_if.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_if.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_if.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // front: raw value, checksum, segment search
  always_comb begin
    logic [7:0]      sum;
    logic [SegW-1:0] cnt;
    logic [SegW-1:0] top;
    sum = in_if.checksum_byte + in_if.flow_high + in_if.flow_low + in_if.extra_a
        + in_if.extra_b;
    top = range_select_q ? SegW'(Points15 - 2) : SegW'(Points7 - 2);
    front_d.raw  = {in_if.flow_high[3:0], in_if.flow_low};
    front_d.ok   = (sum == 8'd0);
    front_d.lo   = (front_d.raw <= RawFloor);
    front_d.hi   = (front_d.raw >= RawCeil);
    front_d.rsel = range_select_q;
    cnt = '0;
    for (int i = 1; i <= MaxPoints - 2; i++) begin
      if (SegW'(i) <= top && front_d.raw > bp_raw(range_select_q, SegW'(i))) begin
        cnt = SegW'(i);
      end
    end
    front_d.seg = cnt;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      front_q <= front_d;
    end
  end

  // table lookup
  always_comb begin
    logic [RawW-1:0]   r0;
    logic [RawW-1:0]   r1;
    logic [SpeedW-1:0] v1;
    logic [RawW-1:0]   span;
    logic [RawW-1:0]   diff;
    logic [SpeedW-1:0] dvw;
    r0 = bp_raw(front_q.rsel, front_q.seg);
    r1 = bp_raw(front_q.rsel, front_q.seg + SegW'(1));
    v1 = bp_speed(front_q.rsel, front_q.seg + SegW'(1));
    look_d.raw  = front_q.raw;
    look_d.ok   = front_q.ok;
    look_d.lo   = front_q.lo;
    look_d.hi   = front_q.hi;
    look_d.rsel = front_q.rsel;
    look_d.v0   = bp_speed(front_q.rsel, front_q.seg);
    span        = r1 - r0;
    diff        = front_q.raw - r0;
    dvw         = v1 - look_d.v0;
    look_d.win  = span[WinW-1:0];
    look_d.offs = diff[WinW-1:0];
    look_d.dv   = dvw[DvW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      look_q <= look_d;
    end
  end

  // multiply
  always_comb begin
    mul_d.raw  = look_q.raw;
    mul_d.ok   = look_q.ok;
    mul_d.lo   = look_q.lo;
    mul_d.hi   = look_q.hi;
    mul_d.rsel = look_q.rsel;
    mul_d.v0   = look_q.v0;
    mul_d.win  = look_q.win;
    mul_d.rem  = NumW'(look_q.dv) * NumW'(look_q.offs);
    mul_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      mul_q <= mul_d;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar i = 0; i < QuoW; i++) begin : g_div
    localparam int Bit = QuoW - 1 - i;

    if (i == 0) begin : g_first
      assign div_in[i] = mul_q;
    end else begin : g_next
      assign div_in[i] = div_q[i-1];
    end

    always_comb begin
      logic [NumW-1:0] dsh;
      dsh = NumW'(div_in[i].win) << Bit;
      div_d[i] = div_in[i];
      if (div_in[i].rem >= dsh) begin
        div_d[i].rem      = div_in[i].rem - dsh;
        div_d[i].quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[3+i]) begin
        div_q[i] <= div_d[i];
      end
    end
  end

  // final speed select
  always_comb begin
    res_d.raw = div_q[QuoW-1].raw;
    res_d.ok  = div_q[QuoW-1].ok;
    if (div_q[QuoW-1].lo) begin
      res_d.speed = '0;
    end else if (div_q[QuoW-1].hi) begin
      res_d.speed = div_q[QuoW-1].rsel ? MaxSpeed15 : MaxSpeed7;
    end else begin
      res_d.speed = div_q[QuoW-1].v0 + SpeedW'(div_q[QuoW-1].quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NumStages-1]) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid          = valid_q[NumStages-1];
  assign out_if.raw_flow       = res_q.raw;
  assign out_if.speed_mm_per_s = res_q.speed;
  assign out_if.checksum_ok    = res_q.ok;

endmodule

/* hdl/afs_checker.sv */
module afs_checker
  import afs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [RawW-1:0]   raw_flow_i,
  input logic [SpeedW-1:0] speed_i
);

  // a stalled result item stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(speed_i) && $stable(raw_flow_i))
    else $error("result item changed while stalled");

  a_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && raw_flow_i <= RawFloor |-> speed_i == '0)
    else $error("speed not zero below floor");

  a_high_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && raw_flow_i >= RawCeil |-> speed_i == MaxSpeed7 || speed_i == MaxSpeed15)
    else $error("speed not at range maximum above ceiling");

  a_mid_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && raw_flow_i > RawFloor && raw_flow_i < RawCeil |-> speed_i < MaxSpeed15)
    else $error("interpolated speed out of range");

endmodule

bind airflow_frame_to_speed_core afs_checker u_afs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .raw_flow_i  (out_if.raw_flow),
  .speed_i     (out_if.speed_mm_per_s)
);

/* bench/testbench.sv */
module testbench;
  import afs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;

  // breakpoints per range, range 0 padded with its last point
  localparam int unsigned KneeRaw [2][13] = '{
    '{409, 915, 1522, 2066, 2523, 2908, 3256, 3572, 3686, 3686, 3686, 3686, 3686},
    '{409, 1203, 1597, 1908, 2187, 2400, 2629, 2801, 3006, 3178, 3309, 3563, 3686}
  };
  localparam int unsigned KneeSpeed [2][13] = '{
    '{0, 1070, 2010, 3000, 3970, 4960, 5980, 6990, 7230, 7230, 7230, 7230, 7230},
    '{0, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000, 11000, 13000, 15000}
  };

  typedef struct packed {
    logic [7:0] cs;
    logic [7:0] fh;
    logic [7:0] fl;
    logic [7:0] ea;
    logic [7:0] eb;
  } frame_t;

  typedef struct packed {
    logic        rsel;
    frame_t      frame;
    logic        typed;
    logic [11:0] raw;
    logic [13:0] speed;
    logic        ok;
  } plan_row_t;

  localparam int PlanRows = 19;

  // fixed expectations only where they follow directly from the tables
  plan_row_t directed_plan [PlanRows] = '{
    '{1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 12'd0,    14'd0,     1'b1},
    '{1'b0, '{8'h66, 8'h01, 8'h99, 8'h00, 8'h00}, 1'b1, 12'd409,  14'd0,     1'b1},
    '{1'b0, '{8'h76, 8'hF1, 8'h99, 8'h00, 8'h00}, 1'b1, 12'd409,  14'd0,     1'b1},
    '{1'b0, '{8'h00, 8'h01, 8'h9A, 8'h00, 8'h00}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b0, '{8'h5A, 8'h03, 8'h93, 8'h00, 8'h00}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b0, '{8'h3C, 8'h08, 8'h12, 8'hA5, 8'h5A}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b0, '{8'h00, 8'h0E, 8'h65, 8'h00, 8'h00}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b0, '{8'h8C, 8'h0E, 8'h66, 8'h00, 8'h00}, 1'b1, 12'd3686, 14'd7230,  1'b1},
    '{1'b0, '{8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 12'd4095, 14'd7230,  1'b1},
    '{1'b0, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 12'd0,    14'd0,     1'b0},
    '{1'b0, '{8'h00, 8'h05, 8'h00, 8'h12, 8'h34}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b1, '{8'h66, 8'h01, 8'h99, 8'h00, 8'h00}, 1'b1, 12'd409,  14'd0,     1'b1},
    '{1'b1, '{8'h00, 8'h04, 8'hB3, 8'h00, 8'h00}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b1, '{8'h00, 8'h0D, 8'hEB, 8'h00, 8'h00}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b1, '{8'h00, 8'h0E, 8'h65, 8'h00, 8'h00}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b1, '{8'h8C, 8'h0E, 8'h66, 8'h00, 8'h00}, 1'b1, 12'd3686, 14'd15000, 1'b1},
    '{1'b1, '{8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 12'd4095, 14'd15000, 1'b1},
    '{1'b1, '{8'hC3, 8'h09, 8'hC4, 8'h00, 8'h7E}, 1'b0, 12'd0,    14'd0,     1'b0},
    '{1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 12'd0,    14'd0,     1'b1}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  afs_in_if  in_bus ();
  afs_out_if out_bus ();

  airflow_frame_to_speed_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_bus),
    .out_if      (out_bus)
  );

  result_t     pending_readings [$];
  logic        active_range;
  bit          idle_on;
  bit          hold_request;
  int unsigned mismatch_count;
  int unsigned frames_sent;
  int unsigned bad_sum_frames;
  int unsigned readings_checked;
  int unsigned frames_per_range [2];

  function automatic logic [13:0] airspeed_for(logic rsel, logic [11:0] raw);
    int unsigned r;
    int unsigned seg;
    int unsigned r0;
    int unsigned r1;
    int unsigned v0;
    int unsigned v1;
    r = raw;
    if (r <= KneeRaw[rsel][0]) return '0;
    if (r >= KneeRaw[rsel][12]) return 14'(KneeSpeed[rsel][12]);
    seg = 0;
    for (int i = 0; i < 13; i++) begin
      if (r > KneeRaw[rsel][i]) seg = i;
    end
    r0 = KneeRaw[rsel][seg];
    r1 = KneeRaw[rsel][seg + 1];
    v0 = KneeSpeed[rsel][seg];
    v1 = KneeSpeed[rsel][seg + 1];
    return 14'(v0 + ((v1 - v0) * (r - r0)) / (r1 - r0));
  endfunction

  function automatic result_t predict_reading(frame_t f, logic rsel);
    result_t    res;
    logic [7:0] total;
    total     = f.cs + f.fh + f.fl + f.ea + f.eb;
    res.raw   = {f.fh[3:0], f.fl};
    res.speed = airspeed_for(rsel, res.raw);
    res.ok    = (total == 8'h00);
    return res;
  endfunction

  // raw spread over floor, ceiling, around breakpoints and inside segments
  function automatic frame_t random_frame(logic rsel);
    frame_t      f;
    int unsigned raw;
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      raw = $urandom_range(0, 409);
    end else if (pick == 1) begin
      raw = $urandom_range(3686, 4095);
    end else if (pick == 2) begin
      raw = KneeRaw[rsel][$urandom_range(0, 12)] + $urandom_range(0, 2) - 1;
    end else begin
      raw = $urandom_range(410, 3685);
    end
    f.fh      = 8'($urandom);
    f.fh[3:0] = raw[11:8];
    f.fl      = raw[7:0];
    f.ea      = 8'($urandom);
    f.eb      = 8'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      f.cs = 8'h00 - f.fh - f.fl - f.ea - f.eb;
    end else begin
      f.cs = 8'($urandom);
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_frame(frame_t f, result_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_bus.valid         = 1'b1;
    in_bus.checksum_byte = f.cs;
    in_bus.flow_high     = f.fh;
    in_bus.flow_low      = f.fl;
    in_bus.extra_a       = f.ea;
    in_bus.extra_b       = f.eb;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_readings.push_back(want);
    frames_sent++;
    frames_per_range[active_range]++;
    if (!want.ok) bad_sum_frames++;
    @(negedge clk_i);
  endtask

  task automatic drain_pending();
    in_bus.valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_range(logic rsel);
    drain_pending();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = rsel;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    active_range = rsel;
  endtask

  task automatic random_frames(int unsigned count);
    frame_t f;
    repeat (count) begin
      f = random_frame(active_range);
      send_frame(f, predict_reading(f, active_range));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HoldCycles;
      end
      if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready = 1'b0;
        stall_left    = $urandom_range(1, 16) - 1;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected item raw_flow", out_bus.raw_flow, 0);
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (out_bus.raw_flow !== want.raw)
          report_mismatch("raw_flow", out_bus.raw_flow, want.raw);
        if (out_bus.speed_mm_per_s !== want.speed)
          report_mismatch("speed_mm_per_s", out_bus.speed_mm_per_s, want.speed);
        if (out_bus.checksum_ok !== want.ok)
          report_mismatch("checksum_ok", out_bus.checksum_ok, want.ok);
      end
    end
  end

  initial begin
    result_t want;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.checksum_byte = '0;
    in_bus.flow_high     = '0;
    in_bus.flow_low      = '0;
    in_bus.extra_a       = '0;
    in_bus.extra_b       = '0;
    active_range         = 1'b0;
    idle_on              = 1'b1;
    hold_request         = 1'b0;
    mismatch_count       = 0;
    frames_sent          = 0;
    bad_sum_frames       = 0;
    readings_checked     = 0;
    frames_per_range     = '{0, 0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first rows run on the reset value of the range
    for (int k = 0; k < PlanRows; k++) begin
      if (directed_plan[k].rsel != active_range) set_range(directed_plan[k].rsel);
      if (directed_plan[k].typed) begin
        want.raw   = directed_plan[k].raw;
        want.speed = directed_plan[k].speed;
        want.ok    = directed_plan[k].ok;
      end else begin
        want = predict_reading(directed_plan[k].frame, active_range);
      end
      send_frame(directed_plan[k].frame, want);
    end

    set_range(1'b0);
    random_frames(300);
    // long hold-off on the output side while frames keep coming
    hold_request = 1'b1;
    random_frames(60);

    set_range(1'b1);
    random_frames(150);
    drain_pending();
    random_frames(150);

    set_range(1'b0);
    random_frames(250);

    set_range(1'b1);
    idle_on = 1'b0;
    random_frames(300);

    drain_pending();
    repeat (DrainCycles) @(negedge clk_i);
    $display("covered %0d frames (%0d on the 7 m/s table, %0d on the 15 m/s table)",
             frames_sent, frames_per_range[0], frames_per_range[1]);
    $display("%0d frames had a bad checksum, %0d results checked, %0d mismatches",
             bad_sum_frames, readings_checked, mismatch_count);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
